// ===== src/stroke_cubic_control_points_top_macros.svh =====
// assertion macros shared by the stroke to cubic blocks
// they expect clk and arst_n in the enclosing module
`ifndef STROKE_CUBIC_CONTROL_POINTS_TOP_MACROS_SVH
`define STROKE_CUBIC_CONTROL_POINTS_TOP_MACROS_SVH

// condition holds on every clock out of reset
`define SCC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle
`define SCC_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// consequence holds in the next cycle
`define SCC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/scc_pkg.sv =====
package scc_pkg;

	// coordinate width, signed Q16.4
	localparam int COORD_BITS = 20;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef enum logic [1:0] {
		KIND_MOVE  = 2'd0,
		KIND_LINE  = 2'd1,
		KIND_CUBIC = 2'd2
	} seg_kind_t;

	// input word: one stroke point
	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   stroke_end;
	} point_word_t;

	// output word: one path segment
	typedef struct packed {
		seg_kind_t segment_kind;
		coord_t    ctrl_a_x;
		coord_t    ctrl_a_y;
		coord_t    ctrl_b_x;
		coord_t    ctrl_b_y;
		coord_t    target_x;
		coord_t    target_y;
		logic      path_done;
	} seg_word_t;

	// segments made by one point, handed to the result queue
	typedef struct packed {
		logic      push0;
		logic      push1;
		seg_word_t seg0;
		seg_word_t seg1;
	} seg_push_t;

endpackage

// ===== src/scc_seg_gen.sv =====
module scc_seg_gen
	import scc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  point_word_t pt,
	output seg_push_t   push
);

	localparam int EW = COORD_BITS + 2;
	localparam logic signed [EW-1:0] SAT_HI = EW'((2**(COORD_BITS-1)) - 1);
	localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

	// floor((a - b) / 8), sign extended
	function automatic logic signed [EW-1:0] tan_step(input coord_t a, input coord_t b);
		logic signed [COORD_BITS:0] d;
		d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
		return EW'(d >>> 3);
	endfunction

	function automatic coord_t sat_c(input logic signed [EW-1:0] v);
		coord_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[COORD_BITS-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[COORD_BITS-1:0];
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic coord_t plus_t(input coord_t p, input logic signed [EW-1:0] t);
		return sat_c(EW'(p) + t);
	endfunction

	function automatic coord_t minus_t(input coord_t p, input logic signed [EW-1:0] t);
		return sat_c(EW'(p) - t);
	endfunction

	// stroke state
	coord_t older_x_q, older_y_q, newer_x_q, newer_y_q, pend_x_q, pend_y_q;
	logic [1:0] seen_q;

	coord_t older_x_d, older_y_d, newer_x_d, newer_y_d, pend_x_d, pend_y_d;
	logic [1:0] seen_d;

	logic signed [EW-1:0] mid_tx, mid_ty, end_tx, end_ty, first_tx, first_ty;
	coord_t out_x, out_y;

	// tangents for the held point and for the incoming point
	always_comb begin
		mid_tx   = tan_step(pt.point_x, older_x_q);
		mid_ty   = tan_step(pt.point_y, older_y_q);
		end_tx   = tan_step(pt.point_x, newer_x_q);
		end_ty   = tan_step(pt.point_y, newer_y_q);
		first_tx = end_tx;
		first_ty = end_ty;
		out_x    = plus_t(newer_x_q, mid_tx);
		out_y    = plus_t(newer_y_q, mid_ty);
	end

	// segment selection and next state
	always_comb begin
		push      = '0;
		older_x_d = older_x_q;
		older_y_d = older_y_q;
		newer_x_d = newer_x_q;
		newer_y_d = newer_y_q;
		pend_x_d  = pend_x_q;
		pend_y_d  = pend_y_q;
		seen_d    = seen_q;
		case (seen_q)
			2'd0: begin
				if (!pt.stroke_end) begin
					newer_x_d = pt.point_x;
					newer_y_d = pt.point_y;
					seen_d    = 2'd1;
				end
			end
			2'd1: begin
				push.push0             = 1'b1;
				push.seg0.segment_kind = KIND_MOVE;
				push.seg0.target_x     = newer_x_q;
				push.seg0.target_y     = newer_y_q;
				if (pt.stroke_end) begin
					push.push1             = 1'b1;
					push.seg1.segment_kind = KIND_LINE;
					push.seg1.target_x     = pt.point_x;
					push.seg1.target_y     = pt.point_y;
					push.seg1.path_done    = 1'b1;
					older_x_d = '0;
					older_y_d = '0;
					newer_x_d = '0;
					newer_y_d = '0;
					pend_x_d  = '0;
					pend_y_d  = '0;
					seen_d    = 2'd0;
				end else begin
					pend_x_d  = plus_t(newer_x_q, first_tx);
					pend_y_d  = plus_t(newer_y_q, first_ty);
					older_x_d = newer_x_q;
					older_y_d = newer_y_q;
					newer_x_d = pt.point_x;
					newer_y_d = pt.point_y;
					seen_d    = 2'd2;
				end
			end
			2'd2: begin
				push.push0             = 1'b1;
				push.seg0.segment_kind = KIND_CUBIC;
				push.seg0.ctrl_a_x     = pend_x_q;
				push.seg0.ctrl_a_y     = pend_y_q;
				push.seg0.ctrl_b_x     = minus_t(newer_x_q, mid_tx);
				push.seg0.ctrl_b_y     = minus_t(newer_y_q, mid_ty);
				push.seg0.target_x     = newer_x_q;
				push.seg0.target_y     = newer_y_q;
				if (pt.stroke_end) begin
					push.push1             = 1'b1;
					push.seg1.segment_kind = KIND_CUBIC;
					push.seg1.ctrl_a_x     = out_x;
					push.seg1.ctrl_a_y     = out_y;
					push.seg1.ctrl_b_x     = minus_t(pt.point_x, end_tx);
					push.seg1.ctrl_b_y     = minus_t(pt.point_y, end_ty);
					push.seg1.target_x     = pt.point_x;
					push.seg1.target_y     = pt.point_y;
					push.seg1.path_done    = 1'b1;
					older_x_d = '0;
					older_y_d = '0;
					newer_x_d = '0;
					newer_y_d = '0;
					pend_x_d  = '0;
					pend_y_d  = '0;
					seen_d    = 2'd0;
				end else begin
					pend_x_d  = out_x;
					pend_y_d  = out_y;
					older_x_d = newer_x_q;
					older_y_d = newer_y_q;
					newer_x_d = pt.point_x;
					newer_y_d = pt.point_y;
				end
			end
			default: begin
				seen_d = 2'd0;
			end
		endcase
		push.push0 = push.push0 & fire;
		push.push1 = push.push1 & fire;
	end

	// state update on each consumed point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_x_q <= '0;
			older_y_q <= '0;
			newer_x_q <= '0;
			newer_y_q <= '0;
			pend_x_q  <= '0;
			pend_y_q  <= '0;
			seen_q    <= 2'd0;
		end else if (fire) begin
			older_x_q <= older_x_d;
			older_y_q <= older_y_d;
			newer_x_q <= newer_x_d;
			newer_y_q <= newer_y_d;
			pend_x_q  <= pend_x_d;
			pend_y_q  <= pend_y_d;
			seen_q    <= seen_d;
		end
	end

	`include "stroke_cubic_control_points_top_macros.svh"

	`SCC_ASSERT_ALWAYS(a_seen_range, seen_q != 2'd3, "point count out of range")
	`SCC_ASSERT_NEXT(a_end_clears, fire && pt.stroke_end, seen_q == 2'd0, "stroke end kept state")
	`SCC_ASSERT_NEXT(a_two_need_end, push.push1, seen_q == 2'd0, "second segment without stroke end")

endmodule

// ===== src/scc_seg_queue.sv =====
module scc_seg_queue
	import scc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  seg_push_t push,
	output logic      room,
	output logic      seg_valid,
	input  logic      seg_stall,
	output seg_word_t seg
);

	localparam int Q_DEPTH = 4;
	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	seg_word_t mem_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic pop;
	logic [CW-1:0] n_push;

	assign pop       = seg_valid & ~seg_stall;
	assign seg_valid = (cnt_q != '0);
	assign seg       = mem_q[rd_ptr_q];
	// room for two words without looking at this cycle's pop
	assign room      = (cnt_q <= CW'(Q_DEPTH - 2));
	assign n_push    = CW'(push.push0) + CW'(push.push1);

	// storage, up to two writes per cycle
	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= push.seg0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_q + PW'(1)] <= push.seg1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + n_push - CW'(pop);
		end
	end

	`include "stroke_cubic_control_points_top_macros.svh"

	`SCC_ASSERT_ALWAYS(a_cnt_max, cnt_q <= CW'(Q_DEPTH), "queue over depth")
	`SCC_ASSERT_NEXT(a_push_order, push.push1 && !push.push0, 1'b0, "second word without first")
	`SCC_ASSERT_NEXT(a_push_room, (push.push0 || push.push1) && !room, 1'b0, "write with no room")

endmodule

// ===== src/stroke_cubic_control_points_top.sv =====
// an accepted point waits in the input register, then fires into the result queue.
// throughput: one point per cycle; a point that ends a stroke of two or more points
// gives two words, which leave the four-word queue one per cycle when seg_stall
// is low; the input register waits while the queue holds more than two words
// reset: arst_n clears the stroke state, queue pointers and valid flags at once
module stroke_cubic_control_points_top
	import scc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        point_valid,
	output logic        point_stall,
	input  point_word_t point,
	output logic        seg_valid,
	input  logic        seg_stall,
	output seg_word_t   seg
);

	logic        valid_s1;
	point_word_t point_s1;
	logic        room;
	logic        fire;
	seg_push_t   push;

	assign fire        = valid_s1 & room;
	assign point_stall = valid_s1 & ~room;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!point_stall) begin
			valid_s1 <= point_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (point_valid && !point_stall) begin
			point_s1 <= point;
		end
	end

	// segment generation and stroke state
	scc_seg_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.pt     (point_s1),
		.push   (push)
	);

	// result queue
	scc_seg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg)
	);

endmodule
